FILE: hdl/crc_fp_pkg.sv
`default_nettype none
package crc_fp_pkg;

  localparam logic [15:0] CrcInit  = 16'hFFFF;
  localparam logic [15:0] CrcPoly  = 16'h1021;
  localparam logic [7:0]  SyncA    = 8'hAA;
  localparam logic [7:0]  SyncB    = 8'h55;
  localparam logic [7:0]  Version  = 8'h01;

  localparam int unsigned QueueDepth = 4;
  localparam int unsigned PtrW       = $clog2(QueueDepth);
  localparam int unsigned CntW       = $clog2(QueueDepth + 1);

  typedef enum logic [0:0] {
    KIND_PAYLOAD = 1'b0,
    KIND_VERDICT = 1'b1
  } result_kind_e;

  typedef enum logic [8:0] {
    PH_IDLE    = 9'b0_0000_0001,
    PH_SYNC_A  = 9'b0_0000_0010,
    PH_SYNC_B  = 9'b0_0000_0100,
    PH_VER     = 9'b0_0000_1000,
    PH_TYPE    = 9'b0_0001_0000,
    PH_LEN     = 9'b0_0010_0000,
    PH_PAYLOAD = 9'b0_0100_0000,
    PH_CRC_LO  = 9'b0_1000_0000,
    PH_CRC_HI  = 9'b1_0000_0000
  } phase_e;

  typedef struct packed {
    logic [7:0] byte_in;
    logic       first_byte;
    logic       final_byte;
  } in_beat_t;

  typedef struct packed {
    logic       result_kind;
    logic [7:0] payload_byte;
    logic [7:0] frame_type;
    logic [7:0] payload_length;
    logic       frame_ok;
    logic       last_result;
  } out_beat_t;

  // number of result beats the front hands to the queue this cycle
  typedef struct packed {
    logic [1:0] num;
  } push_t;

  // crc-16 ccitt-false, one byte msb first
  function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ CrcPoly;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage
`default_nettype wire

FILE: hdl/crc_fp_front.sv
`default_nettype none
module crc_fp_front #(
  parameter int unsigned MaxPayload = 128
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  in_valid_i,
  input  wire logic                  in_stall_i,
  input  wire crc_fp_pkg::in_beat_t  in_data_i,
  output crc_fp_pkg::push_t          push_o,
  output crc_fp_pkg::out_beat_t      slot0_o,
  output crc_fp_pkg::out_beat_t      slot1_o
);
  import crc_fp_pkg::*;

  phase_e      phase_q, phase_d;
  logic [15:0] crc_q, crc_d;
  logic [7:0]  type_q, type_d;
  logic [7:0]  len_q, len_d;
  logic [7:0]  cnt_q, cnt_d;
  logic [7:0]  lo_q, lo_d;

  out_beat_t e0, e1, e2;
  logic      v0, v1, v2;
  logic      accept;

  function automatic out_beat_t verdict(input logic [7:0] t, input logic [7:0] l,
                                        input logic ok);
    out_beat_t r;
    r.result_kind    = KIND_VERDICT;
    r.payload_byte   = '0;
    r.frame_type     = t;
    r.payload_length = l;
    r.frame_ok       = ok;
    r.last_result    = 1'b1;
    return r;
  endfunction

  assign accept = in_valid_i && !in_stall_i;

  always_comb begin
    logic [7:0]  b;
    logic [15:0] upd;
    logic [7:0]  cnt_inc;
    b       = in_data_i.byte_in;
    phase_d = phase_q;
    crc_d   = crc_q;
    type_d  = type_q;
    len_d   = len_q;
    cnt_d   = cnt_q;
    lo_d    = lo_q;
    v0 = 1'b0;
    v1 = 1'b0;
    v2 = 1'b0;
    // open frame cut short by a new first byte
    e0 = verdict(type_q, 8'h00, 1'b0);
    e1 = verdict(type_q, 8'h00, 1'b0);

    if (in_data_i.first_byte) begin
      v0      = (phase_q != PH_IDLE);
      phase_d = PH_SYNC_A;
      crc_d   = CrcInit;
      type_d  = '0;
      len_d   = '0;
      cnt_d   = '0;
      lo_d    = '0;
    end

    upd     = crc16_byte(crc_d, b);
    cnt_inc = cnt_d + 8'd1;
    e1      = verdict(type_d, 8'h00, 1'b0);

    unique case (phase_d)
      PH_IDLE: begin
      end
      PH_SYNC_A: begin
        if (b == SyncA) phase_d = PH_SYNC_B;
        else begin
          v1 = 1'b1;
          phase_d = PH_IDLE;
        end
      end
      PH_SYNC_B: begin
        if (b == SyncB) phase_d = PH_VER;
        else begin
          v1 = 1'b1;
          phase_d = PH_IDLE;
        end
      end
      PH_VER: begin
        if (b == Version) begin
          crc_d   = upd;
          phase_d = PH_TYPE;
        end else begin
          v1 = 1'b1;
          phase_d = PH_IDLE;
        end
      end
      PH_TYPE: begin
        type_d  = b;
        crc_d   = upd;
        phase_d = PH_LEN;
      end
      PH_LEN: begin
        len_d = b;
        if (b > 8'(MaxPayload)) begin
          v1 = 1'b1;
          phase_d = PH_IDLE;
        end else begin
          crc_d   = upd;
          cnt_d   = '0;
          phase_d = (b != 8'h00) ? PH_PAYLOAD : PH_CRC_LO;
        end
      end
      PH_PAYLOAD: begin
        v1              = 1'b1;
        e1              = '0;
        e1.result_kind  = KIND_PAYLOAD;
        e1.payload_byte = b;
        crc_d           = upd;
        cnt_d           = cnt_inc;
        if (cnt_inc >= len_d) phase_d = PH_CRC_LO;
      end
      PH_CRC_LO: begin
        lo_d    = b;
        phase_d = PH_CRC_HI;
      end
      PH_CRC_HI: begin
        v1 = 1'b1;
        if ({b, lo_d} == crc_d) e1 = verdict(type_d, len_d, 1'b1);
        else                    e1 = verdict(type_d, 8'h00, 1'b0);
        phase_d = PH_IDLE;
      end
      default: begin
        phase_d = PH_IDLE;
      end
    endcase

    // buffer ended before the trailer was complete
    e2 = verdict(type_d, 8'h00, 1'b0);
    if (in_data_i.final_byte && (phase_d != PH_IDLE)) begin
      v2      = 1'b1;
      phase_d = PH_IDLE;
    end
  end

  // pack up to two results in order
  always_comb begin
    slot0_o = v0 ? e0 : (v1 ? e1 : e2);
    slot1_o = (v0 && v1) ? e1 : e2;
    push_o.num = '0;
    if (accept) begin
      push_o.num = 2'({1'b0, v0} + {1'b0, v1} + {1'b0, v2});
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      crc_q   <= CrcInit;
      type_q  <= '0;
      len_q   <= '0;
      cnt_q   <= '0;
      lo_q    <= '0;
    end else if (accept) begin
      phase_q <= phase_d;
      crc_q   <= crc_d;
      type_q  <= type_d;
      len_q   <= len_d;
      cnt_q   <= cnt_d;
      lo_q    <= lo_d;
    end
  end

endmodule
`default_nettype wire

FILE: hdl/crc_fp_queue.sv
`default_nettype none
module crc_fp_queue (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire crc_fp_pkg::push_t      push_i,
  input  wire crc_fp_pkg::out_beat_t  slot0_i,
  input  wire crc_fp_pkg::out_beat_t  slot1_i,
  output logic                        room_o,
  output logic                        out_valid_o,
  input  wire logic                   out_stall_i,
  output crc_fp_pkg::out_beat_t       out_data_o
);
  import crc_fp_pkg::*;

  out_beat_t         mem_q [QueueDepth];
  logic [PtrW-1:0]   wr_q, rd_q;
  logic [CntW-1:0]   cnt_q, cnt_d;
  logic              pop;

  // room for the worst case of two results from one byte
  assign room_o      = (cnt_q <= CntW'(QueueDepth - 2));
  assign out_valid_o = (cnt_q != '0);
  assign out_data_o  = mem_q[rd_q];
  assign pop         = out_valid_o && !out_stall_i;

  assign cnt_d = cnt_q + CntW'(push_i.num) - CntW'(pop);

  always_ff @(posedge clk_i) begin
    if (push_i.num != 2'd0) mem_q[wr_q] <= slot0_i;
    if (push_i.num == 2'd2) mem_q[wr_q + PtrW'(1)] <= slot1_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_q + PtrW'(push_i.num);
      if (pop) rd_q <= rd_q + PtrW'(1);
      cnt_q <= cnt_d;
    end
  end

endmodule
`default_nettype wire

FILE: hdl/crc_frame_parser.sv
// crc_frame_parser: streaming parser for framed packets
//   0xAA 0x55 version type length payload[length] crc_lo crc_hi
// input channel: one buffer byte per beat with first/final flags, taken
//   when in_valid_i is high and in_stall_o is low
// output channel: result beats, taken when out_valid_o is high and
//   out_stall_i is low; payload bytes are forwarded tentatively, one
//   verdict beat (last_result set) closes each frame
// crc-16 ccitt-false over version, type, length and payload, checked
//   against the little-endian trailer
// results are registered into the result queue as their bytes are taken
// throughput: one byte per cycle unless stalled; a byte causing two results
//   (open frame cut by a new first byte, or early end of buffer) queues both
// the front parser writes into a four-beat result queue; in_stall_o rises
//   when fewer than two queue slots are free, so a stalled receiver only
//   backs up into the input once the queue holds more than two beats
// reset: parser idle (bytes ignored until a first byte), queue empty
`default_nettype none
module crc_frame_parser #(
  parameter int unsigned MaxPayload = 128
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  in_valid_i,
  output logic                       in_stall_o,
  input  wire crc_fp_pkg::in_beat_t  in_data_i,
  output logic                       out_valid_o,
  input  wire logic                  out_stall_i,
  output crc_fp_pkg::out_beat_t      out_data_o
);
  import crc_fp_pkg::*;

  push_t     push;
  out_beat_t slot0, slot1;
  logic      room;

  // stall depends on queue fill only, never on in_valid_i
  assign in_stall_o = !room;

  // parser, crc and framing checks
  crc_fp_front #(
    .MaxPayload(MaxPayload)
  ) u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .in_stall_i(in_stall_o),
    .in_data_i (in_data_i),
    .push_o    (push),
    .slot0_o   (slot0),
    .slot1_o   (slot1)
  );

  // result queue, head drives the output channel
  crc_fp_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .slot0_i    (slot0),
    .slot1_i    (slot1),
    .room_o     (room),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

endmodule
`default_nettype wire

FILE: tb/sv/crc_frame_parser_tb.sv
module crc_frame_parser_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import crc_fp_pkg::*;

  localparam int MAX_LEN      = 128;     // matches the default MaxPayload of the block
  localparam int ITEM_TARGET  = 1700;    // frame bytes in the random part
  localparam int RUN_LIMIT    = 300000;  // cycles, far above the slowest correct run
  localparam int DRAIN_CYCLES = 32;      // result queue is four beats deep, stalls included

  // ways a random frame is spoiled on purpose
  typedef enum int {
    FR_GOOD,
    FR_DAMAGED,
    FR_BAD_SYNC_A,
    FR_BAD_SYNC_B,
    FR_BAD_VERSION,
    FR_OVERSIZE,
    FR_CUT_FINAL,
    FR_CUT_OPEN
  } flaw_e;

  // --------------------------------------------------------------------------
  // frame checker: tracks the parse of every accepted byte and holds the
  // result beats the block owes, oldest first
  // --------------------------------------------------------------------------
  class frame_checker;
    phase_e      phase;
    logic [15:0] crc;
    logic [7:0]  held_type;
    logic [7:0]  held_len;
    logic [7:0]  byte_count;
    logic [7:0]  crc_lo;
    out_beat_t   awaited_results[$];
    int          errors;
    int          payload_beats;
    int          verdicts;
    int          frames_ok;

    function new();
      phase      = PH_IDLE;
      crc        = CrcInit;
      held_type  = '0;
      held_len   = '0;
      byte_count = '0;
      crc_lo     = '0;
      errors     = 0;
      payload_beats = 0;
      verdicts   = 0;
      frames_ok  = 0;
    endfunction

    // crc-16 ccitt-false, data bits shifted in msb first
    static function logic [15:0] crc_step(input logic [15:0] c, input logic [7:0] d);
      logic [15:0] r;
      logic        fb;
      r = c;
      for (int k = 7; k >= 0; k--) begin
        fb = r[15] ^ d[k];
        r  = {r[14:0], 1'b0} ^ (fb ? CrcPoly : 16'h0000);
      end
      return r;
    endfunction

    function void owe_beat(input logic kind, input logic [7:0] pbyte, input logic [7:0] ftype,
                           input logic [7:0] plen, input logic ok);
      out_beat_t r;
      r.result_kind    = kind;
      r.payload_byte   = pbyte;
      r.frame_type     = ftype;
      r.payload_length = plen;
      r.frame_ok       = ok;
      r.last_result    = kind;
      awaited_results.push_back(r);
    endfunction

    // failed verdict for the frame in progress, parser back to idle
    function void reject();
      owe_beat(KIND_VERDICT, 8'h00, held_type, 8'h00, 1'b0);
      phase = PH_IDLE;
    endfunction

    function void take_byte(input in_beat_t beat);
      logic [7:0] b;
      b = beat.byte_in;
      if (beat.first_byte) begin
        if (phase != PH_IDLE) reject();
        phase      = PH_SYNC_A;
        crc        = CrcInit;
        held_type  = '0;
        held_len   = '0;
        byte_count = '0;
        crc_lo     = '0;
      end
      if (phase == PH_IDLE) return;
      case (phase)
        PH_SYNC_A: if (b == SyncA) phase = PH_SYNC_B; else reject();
        PH_SYNC_B: if (b == SyncB) phase = PH_VER; else reject();
        PH_VER: begin
          if (b == Version) begin
            crc   = crc_step(crc, b);
            phase = PH_TYPE;
          end else begin
            reject();
          end
        end
        PH_TYPE: begin
          held_type = b;
          crc       = crc_step(crc, b);
          phase     = PH_LEN;
        end
        PH_LEN: begin
          held_len = b;
          if (b > MAX_LEN) begin
            reject();
          end else begin
            crc        = crc_step(crc, b);
            byte_count = '0;
            phase      = (b != 0) ? PH_PAYLOAD : PH_CRC_LO;
          end
        end
        PH_PAYLOAD: begin
          owe_beat(KIND_PAYLOAD, b, 8'h00, 8'h00, 1'b0);
          crc        = crc_step(crc, b);
          byte_count = byte_count + 8'd1;
          if (byte_count >= held_len) phase = PH_CRC_LO;
        end
        PH_CRC_LO: begin
          crc_lo = b;
          phase  = PH_CRC_HI;
        end
        PH_CRC_HI: begin
          if ({b, crc_lo} == crc) owe_beat(KIND_VERDICT, 8'h00, held_type, held_len, 1'b1);
          else owe_beat(KIND_VERDICT, 8'h00, held_type, 8'h00, 1'b0);
          phase = PH_IDLE;
        end
        default: phase = PH_IDLE;
      endcase
      // buffer ended with the frame still open
      if (beat.final_byte && phase != PH_IDLE) reject();
    endfunction

    task report(input string msg);
      errors++;
      // keep the log short when things go badly wrong
      if (errors <= 50) $display("mismatch: %s", msg);
    endtask

    task check_result(input out_beat_t got);
      out_beat_t want;
      if (awaited_results.size() == 0) begin
        report($sformatf("unexpected result beat %h", got));
        return;
      end
      want = awaited_results.pop_front();
      if (got.result_kind != want.result_kind)
        report($sformatf("result_kind got %0d want %0d", got.result_kind, want.result_kind));
      if (got.payload_byte != want.payload_byte)
        report($sformatf("payload_byte got %h want %h", got.payload_byte, want.payload_byte));
      if (got.frame_type != want.frame_type)
        report($sformatf("frame_type got %h want %h", got.frame_type, want.frame_type));
      if (got.payload_length != want.payload_length)
        report($sformatf("payload_length got %0d want %0d",
                         got.payload_length, want.payload_length));
      if (got.frame_ok != want.frame_ok)
        report($sformatf("frame_ok got %0d want %0d", got.frame_ok, want.frame_ok));
      if (got.last_result != want.last_result)
        report($sformatf("last_result got %0d want %0d", got.last_result, want.last_result));
      if (want.result_kind == KIND_VERDICT) begin
        verdicts++;
        if (want.frame_ok) frames_ok++;
      end else begin
        payload_beats++;
      end
    endtask
  endclass

  // --------------------------------------------------------------------------
  // clock, reset and block under test
  // --------------------------------------------------------------------------
  logic      clk_i;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  in_beat_t  in_data   = '0;
  logic      out_stall = 1'b0;
  logic      in_stall_o;
  logic      out_valid_o;
  out_beat_t out_data_o;

  logic      steady = 1'b0;       // set during the stretch with no idling on either side
  int        cycle_count = 0;
  int        sent_items  = 0;     // frame bytes handed to the block
  int        noise_items = 0;     // stray bytes between buffers
  int        frames_sent = 0;
  logic [7:0] frame_q[$];         // bytes of the buffer being built

  frame_checker chk;

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  crc_frame_parser u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall),
    .out_data_o  (out_data_o)
  );

  always @(posedge clk_i) cycle_count <= cycle_count + 1;

  // receiver: stalls at random except in the steady stretch
  always @(posedge clk_i) begin
    out_stall <= !steady && ($urandom_range(0, 99) < 31);
  end

  // both channels sampled at the edge, before any driver update lands
  always @(posedge clk_i) begin
    if (rst_n) begin
      if (out_valid_o && !out_stall) chk.check_result(out_data_o);
      if (in_valid && !in_stall_o) chk.take_byte(in_data);
    end
  end

  // watchdog
  initial begin
    wait (cycle_count >= RUN_LIMIT);
    $display("tb: failure");
    $finish;
  end

  // --------------------------------------------------------------------------
  // stimulus
  // --------------------------------------------------------------------------

  // one input beat, with a random gap ahead of it; held until taken
  task automatic send_beat(input logic [7:0] b, input logic first, input logic last);
    in_beat_t beat;
    beat.byte_in    = b;
    beat.first_byte = first;
    beat.final_byte = last;
    while (!steady && $urandom_range(0, 99) < 31) begin
      in_valid <= 1'b0;
      @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_data  <= beat;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
  endtask

  // frame_q as one buffer: first flag on the opening byte, final flag optional
  task automatic send_buffer(input bit with_final);
    for (int i = 0; i < frame_q.size(); i++) begin
      send_beat(frame_q[i], i == 0, with_final && (i == frame_q.size() - 1));
    end
    sent_items += frame_q.size();
    frames_sent++;
  endtask

  // well-formed frame with random payload and a matching trailer
  task automatic build_frame(input int len, input logic [7:0] ftype);
    logic [15:0] c;
    frame_q = {};
    frame_q.push_back(SyncA);
    frame_q.push_back(SyncB);
    frame_q.push_back(Version);
    frame_q.push_back(ftype);
    frame_q.push_back(8'(len));
    for (int i = 0; i < len; i++) frame_q.push_back(8'($urandom));
    c = CrcInit;
    for (int i = 2; i < frame_q.size(); i++) c = frame_checker::crc_step(c, frame_q[i]);
    frame_q.push_back(c[7:0]);
    frame_q.push_back(c[15:8]);
  endtask

  task automatic trim_frame(input int keep);
    while (frame_q.size() > keep) void'(frame_q.pop_back());
  endtask

  initial begin
    int    pick;
    int    len;
    flaw_e flaw;
    bit    with_final;

    chk = new();
    repeat (8) @(posedge clk_i);
    rst_n <= 1'b1;
    @(posedge clk_i);

    // ---- directed part ----
    // byte with no open frame, flagged final: ignored
    send_beat(8'hFF, 1'b0, 1'b1);
    // empty payload, all-ones type, then a stray byte after the trailer
    build_frame(0, 8'hFF);
    frame_q.push_back(8'h00);
    send_buffer(1'b1);
    // frame left open, then a new first byte that also fails the sync check
    frame_q = '{SyncA, SyncB, Version, 8'h00};
    send_buffer(1'b0);
    send_beat(8'h00, 1'b1, 1'b1);
    // wrong version
    frame_q = '{SyncA, SyncB, 8'h00};
    send_buffer(1'b0);
    // wrong second sync byte
    frame_q = '{SyncA, SyncA};
    send_buffer(1'b0);
    // length over the limit on the final byte: a single failed verdict
    frame_q = '{SyncA, SyncB, Version, 8'h5A, 8'h81};
    send_buffer(1'b1);
    // buffer ends right after the version byte
    frame_q = '{SyncA, SyncB, Version};
    send_buffer(1'b1);

    // ---- random part: mostly good frames, the rest spoiled in various ways ----
    sent_items = 0;
    while (sent_items < ITEM_TARGET) begin
      steady = (frames_sent >= 40) && (frames_sent < 70);

      pick = $urandom_range(0, 99);
      if (pick < 4) len = MAX_LEN;
      else if (pick < 10) len = $urandom_range(17, MAX_LEN);
      else len = $urandom_range(0, 16);
      build_frame(len, 8'($urandom));

      pick = $urandom_range(0, 99);
      if (pick < 58) flaw = FR_GOOD;
      else if (pick < 66) flaw = FR_DAMAGED;
      else if (pick < 71) flaw = FR_BAD_SYNC_A;
      else if (pick < 75) flaw = FR_BAD_SYNC_B;
      else if (pick < 79) flaw = FR_BAD_VERSION;
      else if (pick < 84) flaw = FR_OVERSIZE;
      else if (pick < 92) flaw = FR_CUT_FINAL;
      else flaw = FR_CUT_OPEN;

      case (flaw)
        FR_DAMAGED: begin
          pick = $urandom_range(2, frame_q.size() - 1);
          frame_q[pick] = frame_q[pick] ^ (8'h01 << $urandom_range(0, 7));
        end
        FR_BAD_SYNC_A: begin
          frame_q[0] = SyncA ^ 8'($urandom_range(1, 255));
          trim_frame($urandom_range(1, 3));
        end
        FR_BAD_SYNC_B: begin
          frame_q[1] = SyncB ^ 8'($urandom_range(1, 255));
          trim_frame($urandom_range(2, 4));
        end
        FR_BAD_VERSION: begin
          frame_q[2] = Version ^ 8'($urandom_range(1, 255));
          trim_frame($urandom_range(3, 5));
        end
        FR_OVERSIZE: begin
          frame_q[4] = 8'($urandom_range(MAX_LEN + 1, 255));
          trim_frame($urandom_range(5, 7));
        end
        FR_CUT_FINAL, FR_CUT_OPEN: trim_frame($urandom_range(1, frame_q.size() - 1));
        default: begin
          // now and then stray bytes after the trailer
          if ($urandom_range(0, 9) == 0) begin
            repeat ($urandom_range(1, 3)) frame_q.push_back(8'($urandom));
          end
        end
      endcase

      // an open frame is closed by the next buffer's first byte
      with_final = (flaw != FR_CUT_OPEN) &&
                   !(flaw == FR_GOOD && $urandom_range(0, 7) == 0);
      send_buffer(with_final);

      // stray bytes between buffers
      if ($urandom_range(0, 9) == 0) begin
        repeat ($urandom_range(1, 3)) begin
          send_beat(8'($urandom), 1'b0, 1'($urandom));
          noise_items++;
        end
      end
    end
    steady = 1'b0;
    in_valid <= 1'b0;

    // drain, then watch a while longer for stray result beats
    while (chk.awaited_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("run: %0d buffers, %0d random frame bytes, %0d stray bytes, %0d cycles",
             frames_sent, sent_items, noise_items, cycle_count);
    $display("checked %0d payload beats and %0d verdicts (%0d frames accepted)",
             chk.payload_beats, chk.verdicts, chk.frames_ok);
    if (chk.errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
